[design/temporal_mean_filter_unit_assert.svh]
// assertion helpers for the temporal mean filter
`ifndef TEMPORAL_MEAN_FILTER_UNIT_ASSERT_SVH
`define TEMPORAL_MEAN_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off while in reset
`define TMF_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("temporal mean filter check failed");

// next-cycle implication, clocked on clk, off while in reset
`define TMF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("temporal mean filter check failed");

`endif

[design/tmf_pkg.sv]
package tmf_pkg;

    // default sizes
    localparam int DEF_MAX_WINDOW = 16;
    localparam int DEF_MAX_PIXELS = 16384;
    localparam int DEF_PIXEL_BITS = 8;

    // configuration register layout
    localparam int WINDOW_CFG_W = 5;
    localparam int PIXELS_CFG_W = 15;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int REG_SEL_BIT  = 2;

    localparam logic [WINDOW_CFG_W-1:0] WINDOW_RESET = 5'd1;
    localparam logic [PIXELS_CFG_W-1:0] PIXELS_RESET = 15'd16384;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [0:0] {
        REG_WINDOW = 1'b0,
        REG_PIXELS = 1'b1
    } reg_sel_t;

    // per-pixel classification handed from front to back
    typedef struct packed {
        logic first;   // first frame after restart, sum starts from zero
        logic emit;    // window full, a mean is produced
        logic last;    // final pixel of the frame
        logic keep;    // history ring in use (window above one)
    } tmf_ctrl_t;

    // width helpers
    function automatic int win_w(int max_window);
        return $clog2(max_window + 1);
    endfunction

    function automatic int np_w(int max_pixels);
        return $clog2(max_pixels + 1);
    endfunction

    function automatic int pos_w(int max_pixels);
        return (max_pixels > 1) ? $clog2(max_pixels) : 1;
    endfunction

    function automatic int slot_w(int max_window);
        return (max_window > 1) ? $clog2(max_window) : 1;
    endfunction

    function automatic int hist_slots(int max_window);
        return (max_window > 1) ? max_window - 1 : 1;
    endfunction

    function automatic int haddr_w(int max_window, int max_pixels);
        return (hist_slots(max_window) * max_pixels > 1) ?
               $clog2(hist_slots(max_window) * max_pixels) : 1;
    endfunction

    function automatic int sum_w(int max_window, int pixel_bits);
        return $clog2(max_window * ((1 << pixel_bits) - 1) + 1);
    endfunction

    function automatic int recip_shift(int max_window, int pixel_bits);
        return sum_w(max_window, pixel_bits) + win_w(max_window);
    endfunction

    function automatic int recip_w(int max_window, int pixel_bits);
        return recip_shift(max_window, pixel_bits) + 1;
    endfunction

    function automatic int tdata_w(int pixel_bits);
        return ((pixel_bits + 7) >> 3) << 3;
    endfunction

endpackage

[design/tmf_front.sv]
module tmf_front #(
    parameter int MAX_WINDOW = tmf_pkg::DEF_MAX_WINDOW,
    parameter int MAX_PIXELS = tmf_pkg::DEF_MAX_PIXELS,
    parameter int PIXEL_BITS = tmf_pkg::DEF_PIXEL_BITS
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   restart,
    input  logic [tmf_pkg::win_w(MAX_WINDOW)-1:0]                  eff_n,
    input  logic [tmf_pkg::np_w(MAX_PIXELS)-1:0]                   eff_np,
    input  logic                                                   s_tvalid,
    output logic                                                   s_tready,
    input  logic [PIXEL_BITS-1:0]                                  pixel,
    output logic                                                   push_valid,
    input  logic                                                   push_ready,
    output logic [PIXEL_BITS-1:0]                                  item_pixel,
    output logic [tmf_pkg::pos_w(MAX_PIXELS)-1:0]                  item_pos,
    output logic [tmf_pkg::haddr_w(MAX_WINDOW, MAX_PIXELS)-1:0]    item_hidx,
    output tmf_pkg::tmf_ctrl_t                                     item_ctrl
);
    import tmf_pkg::*;

    localparam int WIN_W   = win_w(MAX_WINDOW);
    localparam int NP_W    = np_w(MAX_PIXELS);
    localparam int POS_W   = pos_w(MAX_PIXELS);
    localparam int SLOT_W  = slot_w(MAX_WINDOW);
    localparam int HADDR_W = haddr_w(MAX_WINDOW, MAX_PIXELS);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] seen_reg, seen_next;
    logic [SLOT_W-1:0] slots;
    logic              last;
    logic              accept;

    // handshake straight onto the queue
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    // classify the pixel from the stream position
    assign slots = SLOT_W'(eff_n - WIN_W'(1));
    assign last  = (NP_W'(pos_reg) + NP_W'(1)) == eff_np;

    assign item_pixel      = pixel;
    assign item_pos        = pos_reg;
    assign item_hidx       = HADDR_W'(slot_reg) * HADDR_W'(MAX_PIXELS) + HADDR_W'(pos_reg);
    assign item_ctrl.first = (seen_reg == '0);
    assign item_ctrl.emit  = (seen_reg >= slots);
    assign item_ctrl.last  = last;
    assign item_ctrl.keep  = (slots != '0);

    // position, ring slot and frame count advance
    always_comb
    begin
        pos_next  = pos_reg;
        slot_next = slot_reg;
        seen_next = seen_reg;
        if (restart)
        begin
            pos_next  = '0;
            slot_next = '0;
            seen_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_next = '0;
                if (item_ctrl.keep)
                begin
                    slot_next = (slot_reg + SLOT_W'(1) == slots) ? '0 : slot_reg + SLOT_W'(1);
                end
                if (seen_reg < slots)
                begin
                    seen_next = seen_reg + SLOT_W'(1);
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            slot_reg <= '0;
            seen_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            slot_reg <= slot_next;
            seen_reg <= seen_next;
        end
    end

endmodule

[design/tmf_queue.sv]
module tmf_queue #(
    parameter int DATA_W = 1,
    parameter int DEPTH  = tmf_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entries [0:DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    // occupancy flags
    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer wrap and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/tmf_back.sv]
module tmf_back #(
    parameter int MAX_WINDOW = tmf_pkg::DEF_MAX_WINDOW,
    parameter int MAX_PIXELS = tmf_pkg::DEF_MAX_PIXELS,
    parameter int PIXEL_BITS = tmf_pkg::DEF_PIXEL_BITS
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   q_valid,
    output logic                                                   q_ready,
    input  logic [PIXEL_BITS-1:0]                                  q_pixel,
    input  logic [tmf_pkg::pos_w(MAX_PIXELS)-1:0]                  q_pos,
    input  logic [tmf_pkg::haddr_w(MAX_WINDOW, MAX_PIXELS)-1:0]    q_hidx,
    input  tmf_pkg::tmf_ctrl_t                                     q_ctrl,
    input  logic [tmf_pkg::recip_w(MAX_WINDOW, PIXEL_BITS)-1:0]    recip,
    output logic                                                   out_valid,
    input  logic                                                   out_ready,
    output logic [PIXEL_BITS-1:0]                                  mean,
    output logic                                                   out_last
);
    import tmf_pkg::*;

    localparam int POS_W      = pos_w(MAX_PIXELS);
    localparam int HADDR_W    = haddr_w(MAX_WINDOW, MAX_PIXELS);
    localparam int SUM_W      = sum_w(MAX_WINDOW, PIXEL_BITS);
    localparam int K_SH       = recip_shift(MAX_WINDOW, PIXEL_BITS);
    localparam int RECIP_W    = recip_w(MAX_WINDOW, PIXEL_BITS);
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int HIST_DEPTH = hist_slots(MAX_WINDOW) * MAX_PIXELS;

    // per-position sum and history ring
    logic [SUM_W-1:0]      sum_mem  [0:MAX_PIXELS-1];
    logic [PIXEL_BITS-1:0] hist_mem [0:HIST_DEPTH-1];
    logic [SUM_W-1:0]      sum_rd_reg;
    logic [PIXEL_BITS-1:0] hist_rd_reg;

    // update stage
    logic                  b_valid_reg;
    logic [PIXEL_BITS-1:0] b_pixel_reg;
    logic [POS_W-1:0]      b_pos_reg;
    logic [HADDR_W-1:0]    b_hidx_reg;
    tmf_ctrl_t             b_ctrl_reg;
    logic                  b_fs_reg;
    logic [SUM_W-1:0]      b_fs_val_reg;
    logic                  b_fh_reg;
    logic [PIXEL_BITS-1:0] b_fh_val_reg;

    // multiply stage and output register
    logic                  c_valid_reg;
    logic [SUM_W-1:0]      c_total_reg;
    logic                  c_last_reg;
    logic                  d_valid_reg;
    logic [PROD_W-1:0]     d_prod_reg;
    logic                  d_last_reg;

    logic [SUM_W-1:0]      base, total, new_sum;
    logic [PIXEL_BITS-1:0] oldest;
    logic                  d_ready, c_ready, c_leave, b_leave, load_b, load_c, b_hist_wr, hist_we;

    // stage advance, ready runs back from the output register
    assign d_ready   = !d_valid_reg || out_ready;
    assign c_leave   = c_valid_reg && d_ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign b_leave   = b_valid_reg && (!b_ctrl_reg.emit || c_ready);
    assign load_b    = q_valid && (!b_valid_reg || b_leave);
    assign load_c    = b_leave && b_ctrl_reg.emit;
    assign q_ready   = load_b;
    assign b_hist_wr = !b_ctrl_reg.emit || b_ctrl_reg.keep;
    assign hist_we   = b_leave && b_hist_wr;

    // sum and history update, forwarded values win over stale reads
    always_comb
    begin
        base = '0;
        if (!b_ctrl_reg.first)
        begin
            base = b_fs_reg ? b_fs_val_reg : sum_rd_reg;
        end
        oldest = b_fh_reg ? b_fh_val_reg : hist_rd_reg;
        total  = base + SUM_W'(b_pixel_reg);
        if (!b_ctrl_reg.emit)
        begin
            new_sum = total;
        end
        else if (b_ctrl_reg.keep)
        begin
            new_sum = total - SUM_W'(oldest);
        end
        else
        begin
            new_sum = '0;
        end
    end

    // memories: read on load into the update stage, write when it leaves
    always_ff @(posedge clk)
    begin
        if (b_leave)
        begin
            sum_mem[b_pos_reg] <= new_sum;
        end
        if (load_b)
        begin
            sum_rd_reg <= sum_mem[q_pos];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[b_hidx_reg] <= b_pixel_reg;
        end
        if (load_b)
        begin
            hist_rd_reg <= hist_mem[q_hidx];
        end
    end

    // update stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (load_b)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_leave)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    // update stage payload, with bypass from the request just ahead
    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            b_pixel_reg  <= q_pixel;
            b_pos_reg    <= q_pos;
            b_hidx_reg   <= q_hidx;
            b_ctrl_reg   <= q_ctrl;
            b_fs_reg     <= b_valid_reg && (b_pos_reg == q_pos);
            b_fs_val_reg <= new_sum;
            b_fh_reg     <= b_valid_reg && b_hist_wr && (b_hidx_reg == q_hidx);
            b_fh_val_reg <= b_pixel_reg;
        end
    end

    // multiply stage and output register valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_c)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (c_leave)
            begin
                c_valid_reg <= 1'b0;
            end
            if (c_leave)
            begin
                d_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                d_valid_reg <= 1'b0;
            end
        end
    end

    // divide by n as a multiply by the reciprocal
    always_ff @(posedge clk)
    begin
        if (load_c)
        begin
            c_total_reg <= total;
            c_last_reg  <= b_ctrl_reg.last;
        end
        if (c_leave)
        begin
            d_prod_reg <= PROD_W'(c_total_reg) * PROD_W'(recip);
            d_last_reg <= c_last_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign mean      = d_prod_reg[K_SH +: PIXEL_BITS];
    assign out_last  = d_last_reg;

endmodule

[design/temporal_mean_filter_unit.sv]
// Temporal moving-average filter over n frames (n = 1..16).
// Input stream (s_tvalid/s_tready/s_tdata): one pixel per request in raster order,
// frame after frame. Output stream (m_tvalid/m_tready/m_tdata/m_tlast): the truncated
// mean of that pixel position over the last n frames; m_tlast marks the final pixel
// of a frame. The first n-1 frames after a restart produce no output.
// Registers on the APB port: window_frames at 0x0, frame_pixels at 0x4. Any write
// restarts the stream at pixel 0 of a new first frame; write only while idle.
// Throughput: one pixel per clock, sustained while m_tready is high. Each pixel reads
// and writes one entry of the sum memory, reads one of the history memory and, for n
// above one, writes it; each memory is taken once per cycle. A pixel passes the queue,
// memory read and update, and the reciprocal multiply into the output register.
// Reset: n = 1, 16384 pixels per frame, stream at its start. The memories are not
// cleared; the first frame writes every sum before it is read.
// Stall: the output register holds while m_tready is low, the pipeline stops behind it
// and a 4-entry queue keeps taking pixels; s_tready falls once the queue is full.
module temporal_mean_filter_unit #(
    parameter int MAX_WINDOW = tmf_pkg::DEF_MAX_WINDOW,
    parameter int MAX_PIXELS = tmf_pkg::DEF_MAX_PIXELS,
    parameter int PIXEL_BITS = tmf_pkg::DEF_PIXEL_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [tmf_pkg::tdata_w(PIXEL_BITS)-1:0]    s_tdata,   // pixel
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [tmf_pkg::tdata_w(PIXEL_BITS)-1:0]    m_tdata,   // mean
    output logic                                       m_tlast,   // last_in_frame
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [tmf_pkg::APB_ADDR_W-1:0]             paddr,
    input  logic [tmf_pkg::APB_DATA_W-1:0]             pwdata,
    output logic [tmf_pkg::APB_DATA_W-1:0]             prdata,
    output logic                                       pready
);
    import tmf_pkg::*;

    localparam int WIN_W   = win_w(MAX_WINDOW);
    localparam int NP_W    = np_w(MAX_PIXELS);
    localparam int POS_W   = pos_w(MAX_PIXELS);
    localparam int HADDR_W = haddr_w(MAX_WINDOW, MAX_PIXELS);
    localparam int K_SH    = recip_shift(MAX_WINDOW, PIXEL_BITS);
    localparam int RECIP_W = recip_w(MAX_WINDOW, PIXEL_BITS);
    localparam int TDATA_W = tdata_w(PIXEL_BITS);
    localparam int ITEM_W  = PIXEL_BITS + POS_W + HADDR_W + $bits(tmf_ctrl_t);

    logic [WINDOW_CFG_W-1:0] window_reg;
    logic [PIXELS_CFG_W-1:0] pixels_reg;
    logic                    cfg_wr;
    reg_sel_t                cfg_sel;
    logic [WIN_W-1:0]        eff_n;
    logic [NP_W-1:0]         eff_np;
    logic [RECIP_W-1:0]      recip_tab [0:MAX_WINDOW];
    logic [RECIP_W-1:0]      recip_reg;

    logic                    push_valid, push_ready, pop_valid, pop_ready;
    logic [ITEM_W-1:0]       push_data, pop_data;
    logic [PIXEL_BITS-1:0]   f_pixel, q_pixel, mean;
    logic [POS_W-1:0]        f_pos, q_pos;
    logic [HADDR_W-1:0]      f_hidx, q_hidx;
    tmf_ctrl_t               f_ctrl, q_ctrl;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_sel = reg_sel_t'(paddr[REG_SEL_BIT]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            pixels_reg <= PIXELS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_WINDOW: window_reg <= pwdata[WINDOW_CFG_W-1:0];
                REG_PIXELS: pixels_reg <= pwdata[PIXELS_CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_WINDOW: prdata = APB_DATA_W'(window_reg);
            REG_PIXELS: prdata = APB_DATA_W'(pixels_reg);
        endcase
    end

    // clamp register values into range
    always_comb
    begin
        if (window_reg == '0)
        begin
            eff_n = WIN_W'(1);
        end
        else if (int'(window_reg) > MAX_WINDOW)
        begin
            eff_n = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            eff_n = WIN_W'(window_reg);
        end
        if (pixels_reg == '0)
        begin
            eff_np = NP_W'(1);
        end
        else if (int'(pixels_reg) > MAX_PIXELS)
        begin
            eff_np = NP_W'(MAX_PIXELS);
        end
        else
        begin
            eff_np = NP_W'(pixels_reg);
        end
    end

    // reciprocal table, ceil(2^K / n), exact for every reachable sum
    for (genvar g = 0; g <= MAX_WINDOW; g++)
    begin : g_recip
        localparam longint RV = (g == 0) ? 0 :
                                ((longint'(1) << K_SH) + g - 1) / ((g == 0) ? 1 : g);
        assign recip_tab[g] = RV[RECIP_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        recip_reg <= recip_tab[eff_n];
    end

    // front: accept and classify
    tmf_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_PIXELS (MAX_PIXELS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_wr),
        .eff_n      (eff_n),
        .eff_np     (eff_np),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .pixel      (s_tdata[PIXEL_BITS-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .item_pixel (f_pixel),
        .item_pos   (f_pos),
        .item_hidx  (f_hidx),
        .item_ctrl  (f_ctrl)
    );

    assign push_data = {f_ctrl, f_hidx, f_pos, f_pixel};

    // queue between front and back
    tmf_queue #(
        .DATA_W     (ITEM_W),
        .DEPTH      (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {q_ctrl, q_hidx, q_pos, q_pixel} = pop_data;

    // back: memories, update and divide
    tmf_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_PIXELS (MAX_PIXELS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_pixel    (q_pixel),
        .q_pos      (q_pos),
        .q_hidx     (q_hidx),
        .q_ctrl     (q_ctrl),
        .recip      (recip_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .mean       (mean),
        .out_last   (m_tlast)
    );

    assign m_tdata = TDATA_W'(mean);

endmodule

[design/tmf_checker.sv]
module tmf_checker #(
    parameter int PIXEL_BITS = tmf_pkg::DEF_PIXEL_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tready,
    input  logic                                       m_tvalid,
    input  logic                                       m_tready,
    input  logic [tmf_pkg::tdata_w(PIXEL_BITS)-1:0]    m_tdata,
    input  logic                                       m_tlast,
    input  logic                                       psel,
    input  logic                                       penable,
    input  logic                                       pwrite,
    input  logic [tmf_pkg::APB_ADDR_W-1:0]             paddr,
    input  logic [tmf_pkg::APB_DATA_W-1:0]             pwdata,
    input  logic [tmf_pkg::APB_DATA_W-1:0]             prdata,
    input  logic                                       pready
);
    import tmf_pkg::*;

`include "temporal_mean_filter_unit_assert.svh"

    logic cfg_wr;
    logic sel_window;
    logic sel_pixels;

    assign cfg_wr     = psel && penable && pwrite && pready;
    assign sel_window = (paddr[REG_SEL_BIT] == REG_WINDOW);
    assign sel_pixels = (paddr[REG_SEL_BIT] == REG_PIXELS);

    // a stalled result stays put
    `TMF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // with the output register empty the pipeline drains and the queue frees a slot
    `TMF_ASSERT_NEXT(a_drain_ready, !m_tvalid, s_tready)

    // register writes read back
    `TMF_ASSERT(a_window_rd, (cfg_wr && sel_window) ##1 sel_window, prdata[WINDOW_CFG_W-1:0] == $past(pwdata[WINDOW_CFG_W-1:0]))
    `TMF_ASSERT(a_pixels_rd, (cfg_wr && sel_pixels) ##1 sel_pixels, prdata[PIXELS_CFG_W-1:0] == $past(pwdata[PIXELS_CFG_W-1:0]))

endmodule

bind temporal_mean_filter_unit tmf_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_tmf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_tready   (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);
